>>> src/mfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mfs_pkg;

    localparam int DEF_DOCS      = 1024;
    localparam int DEF_TERMS     = 1024;
    localparam int DEF_FEATURES  = 16;
    localparam int DEF_FRAC_BITS = 12;

    localparam int DW = 24;
    localparam logic [15:0] RATE_RESET = 16'd655;
    localparam logic [15:0] REG_RESET  = 16'd1311;

    typedef enum logic [1:0] {
        CMD_TRAIN     = 2'd0,
        CMD_PREDICT   = 2'd1,
        CMD_LOAD_DOC  = 2'd2,
        CMD_LOAD_TERM = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_RATE = 1'b0,
        CFG_REG  = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOT,
        ST_RESID,
        ST_UPD,
        ST_WB,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input beat
        logic load_wr;   // write one element from the beat
        logic clr_acc;   // clear accumulator
        logic rd_en;     // read element at the feature counter
        logic mac_en;    // accumulate product of the read data
        logic resid;     // form prediction and residual
        logic upd_en;    // write back the updated element
        logic out_load;  // load output register
    } t_dp_cmd;

    function automatic logic signed [DW-1:0] sat24(input logic signed [63:0] x);
        logic signed [DW-1:0] r;
        if (x > 64'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (x < -64'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/mfs_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mfs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [9:0]  doc_sel;
    logic [9:0]  term_sel;
    logic [3:0]  feature_index;
    logic signed [23:0] value;
    modport source (output valid, command, doc_sel, term_sel, feature_index, value,
                    input ready);
    modport sink   (input valid, command, doc_sel, term_sel, feature_index, value,
                    output ready);
endinterface

interface mfs_out_if;
    logic        valid;
    logic        ready;
    logic signed [23:0] prediction;
    logic signed [23:0] residual;
    logic        updated;
    modport source (output valid, prediction, residual, updated, input ready);
    modport sink   (input valid, prediction, residual, updated, output ready);
endinterface

interface mfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/mfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> src/mfs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mfs_datapath import mfs_pkg::*; #(
    parameter int DOCS      = DEF_DOCS,
    parameter int TERMS     = DEF_TERMS,
    parameter int FEATURES  = DEF_FEATURES,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  wire [((FEATURES > 1) ? $clog2(FEATURES) : 1)-1:0] i_feat,
    input  wire                 i_feat_d,
    input  wire [1:0]           i_command,
    input  wire [9:0]           i_doc_sel,
    input  wire [9:0]           i_term_sel,
    input  wire [3:0]           i_feature_index,
    input  wire signed [DW-1:0] i_value,
    input  wire                 i_cfg_we,
    input  wire [0:0]           i_cfg_index,
    input  wire [15:0]          i_cfg_data,
    output logic                o_positive,
    output logic                o_feat_ok,
    output logic signed [DW-1:0] o_prediction,
    output logic signed [DW-1:0] o_residual,
    output logic                o_updated
);
    localparam int DAW = (DOCS > 1) ? $clog2(DOCS) : 1;
    localparam int TAW = (TERMS > 1) ? $clog2(TERMS) : 1;
    localparam int FAW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int DDEPTH = 1 << (DAW + FAW);
    localparam int TDEPTH = 1 << (TAW + FAW);
    localparam int GW = 48;
    localparam logic [31:0] DREC = 32'(((64'd1 << 21) + 64'(DOCS) - 64'd1) / 64'(DOCS));
    localparam logic [31:0] TREC = 32'(((64'd1 << 21) + 64'(TERMS) - 64'd1) / 64'(TERMS));

    logic [15:0] r_rate, r_regw;
    logic [1:0]  r_command;
    logic [DAW-1:0] r_doc;
    logic [TAW-1:0] r_term;
    logic [3:0]  r_fidx;
    logic signed [DW-1:0] r_value;
    logic signed [63:0] r_acc;
    logic signed [DW-1:0] r_pred, r_resid;
    logic [DW-1:0] w_u, w_v;
    logic [FAW-1:0] r_fd;   // feature index of the data on the RAM outputs

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_regw <= REG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RATE: r_rate <= i_cfg_data;
                CFG_REG:  r_regw <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // Beat capture, indices wrapped to the table size by a reciprocal multiply.
    logic [31:0] w_dq, w_tq, w_dmod, w_tmod;
    assign w_dq   = ({22'd0, i_doc_sel} * DREC) >> 21;
    assign w_tq   = ({22'd0, i_term_sel} * TREC) >> 21;
    assign w_dmod = (DOCS >= 1024) ? {22'd0, i_doc_sel}
                                   : {22'd0, i_doc_sel} - w_dq * 32'(DOCS);
    assign w_tmod = (TERMS >= 1024) ? {22'd0, i_term_sel}
                                    : {22'd0, i_term_sel} - w_tq * 32'(TERMS);
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= i_command;
            r_doc     <= w_dmod[DAW-1:0];
            r_term    <= w_tmod[TAW-1:0];
            r_fidx    <= i_feature_index;
            r_value   <= i_value;
        end
    end
    assign o_positive = (r_value > 0);
    assign o_feat_ok  = ({28'd0, r_fidx} < 32'(FEATURES));

    // Gradient of one element from the old values.
    function automatic logic signed [GW-1:0] grad_of(
        input logic signed [DW-1:0] s, input logic signed [DW-1:0] o,
        input logic signed [DW-1:0] e, input logic [15:0] rg);
        logic signed [63:0] g;
        g = ((64'(e) * 64'(o)) >>> FRAC_BITS)
          - ((64'($signed({1'b0, rg})) * 64'(s)) >>> 16);
        return g[GW-1:0];
    endfunction

    // Scaled step added to the old element, saturated.
    function automatic logic signed [DW-1:0] apply_step(
        input logic signed [DW-1:0] s, input logic signed [GW-1:0] g,
        input logic [15:0] rt);
        logic signed [63:0] dl;
        dl = (64'($signed({1'b0, rt})) * 64'(g)) >>> 16;
        return sat24(64'(s) + dl);
    endfunction

    // Gradient stage: registers both gradients and the old elements.
    logic signed [GW-1:0] r_gu, r_gv;
    logic signed [DW-1:0] r_su, r_sv;
    logic [FAW-1:0] r_wf;
    always_ff @(posedge i_clk) begin
        r_gu <= grad_of($signed(w_u), $signed(w_v), r_resid, r_regw);
        r_gv <= grad_of($signed(w_v), $signed(w_u), r_resid, r_regw);
        r_su <= $signed(w_u);
        r_sv <= $signed(w_v);
        r_wf <= r_fd;
    end

    logic signed [DW-1:0] w_nu, w_nv;
    assign w_nu = apply_step(r_su, r_gu, r_rate);
    assign w_nv = apply_step(r_sv, r_gv, r_rate);

    // Table ports: loads and updates write, the walk reads.
    logic [FAW-1:0] w_rf;
    logic d_we, t_we;
    logic [DW-1:0] d_wd, t_wd;
    logic [FAW-1:0] w_wf;
    assign w_rf = i_feat;
    assign d_we = (i_cmd.load_wr && r_command == CMD_LOAD_DOC) || i_cmd.upd_en;
    assign t_we = (i_cmd.load_wr && r_command == CMD_LOAD_TERM) || i_cmd.upd_en;
    assign w_wf = i_cmd.upd_en ? r_wf : r_fidx[FAW-1:0];
    assign d_wd = i_cmd.upd_en ? w_nu : r_value;
    assign t_wd = i_cmd.upd_en ? w_nv : r_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_fd <= w_rf;
        end
    end

    mfs_ram #(.WIDTH(DW), .DEPTH(DDEPTH)) u_doc (
        .i_clk(i_clk), .i_we(d_we), .i_waddr({r_doc, w_wf}), .i_wdata(d_wd),
        .i_re(i_cmd.rd_en), .i_raddr({r_doc, w_rf}), .o_rdata(w_u));
    mfs_ram #(.WIDTH(DW), .DEPTH(TDEPTH)) u_term (
        .i_clk(i_clk), .i_we(t_we), .i_waddr({r_term, w_wf}), .i_wdata(t_wd),
        .i_re(i_cmd.rd_en), .i_raddr({r_term, w_rf}), .o_rdata(w_v));

    // Single multiply-accumulate for the dot product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_acc <= '0;
        end else if (i_cmd.mac_en && i_feat_d) begin
            r_acc <= r_acc + 64'($signed(w_u)) * 64'($signed(w_v));
        end
    end

    // Prediction and residual.
    logic signed [DW-1:0] w_pred;
    assign w_pred = sat24(r_acc >>> FRAC_BITS);
    always_ff @(posedge i_clk) begin
        if (i_cmd.resid) begin
            r_pred  <= w_pred;
            r_resid <= (r_command == CMD_TRAIN) ? sat24(64'(r_value) - 64'(w_pred)) : '0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_prediction <= r_pred;
            o_residual   <= r_resid;
            o_updated    <= (r_command == CMD_TRAIN) && o_positive;
        end
    end
endmodule
`default_nettype wire

>>> src/mfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mfs_ctrl import mfs_pkg::*; #(
    parameter int FEATURES = DEF_FEATURES
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    input  wire [1:0] i_command,
    output logic     o_in_ready,
    input  wire      i_out_ready,
    output logic     o_out_valid,
    input  wire      i_positive,
    input  wire      i_feat_ok,
    output t_dp_cmd  o_cmd,
    output logic [$clog2(FEATURES+1)-1:0] o_feat,
    output logic     o_feat_d
);
    localparam int FCW = $clog2(FEATURES+1);
    localparam logic [FCW-1:0] LAST = FCW'(FEATURES);

    t_state r_state, n_state;
    logic [FCW-1:0] r_feat, n_feat;
    logic r_load, n_load;
    logic r_train, n_train;
    logic r_vld, n_vld;
    logic r_fd, n_fd;
    logic r_fd2, n_fd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_feat  <= '0;
            r_load  <= 1'b0;
            r_train <= 1'b0;
            r_vld   <= 1'b0;
            r_fd    <= 1'b0;
            r_fd2   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_feat  <= n_feat;
            r_load  <= n_load;
            r_train <= n_train;
            r_vld   <= n_vld;
            r_fd    <= n_fd;
            r_fd2   <= n_fd2;
        end
    end

    assign o_feat      = r_feat;
    assign o_feat_d    = r_fd;
    assign o_out_valid = r_vld;

    // Walk the features once for the dot product and, for a positive train beat, once for updates.
    always_comb begin
        n_state = r_state;
        n_feat  = r_feat;
        n_load  = 1'b0;
        n_train = r_train;
        n_fd    = 1'b0;
        n_fd2   = r_fd;
        n_vld   = r_vld && !i_out_ready;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        // A pending load beat is written in the cycle after capture, if its feature index is in range.
        o_cmd.load_wr = r_load && i_feat_ok;
        case (r_state)
            ST_IDLE: begin
                // Hold off a new beat while a load is still being written.
                o_in_ready = !r_load;
                if (i_in_valid && !r_load) begin
                    o_cmd.capture = 1'b1;
                    if (i_command == CMD_LOAD_DOC || i_command == CMD_LOAD_TERM) begin
                        n_load = 1'b1;
                    end else begin
                        n_train = (i_command == CMD_TRAIN);
                        o_cmd.clr_acc = 1'b1;
                        n_feat  = '0;
                        n_state = ST_DOT;
                    end
                end
            end
            ST_DOT: begin
                o_cmd.mac_en = 1'b1;
                if (r_feat != LAST) begin
                    o_cmd.rd_en = 1'b1;
                    n_fd   = 1'b1;
                    n_feat = r_feat + 1'b1;
                end else begin
                    n_state = ST_RESID;
                end
            end
            ST_RESID: begin
                o_cmd.resid = 1'b1;
                n_feat = '0;
                n_state = (r_train && i_positive) ? ST_UPD : ST_OUT;
            end
            ST_UPD: begin
                // Read element k, form its gradients the cycle after, write
                // its new value the cycle after that.
                o_cmd.upd_en = r_fd2;
                if (r_feat != LAST) begin
                    o_cmd.rd_en = 1'b1;
                    n_fd   = 1'b1;
                    n_feat = r_feat + 1'b1;
                end else begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                // Write back the last element.
                o_cmd.upd_en = r_fd2;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_vld || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_vld   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> src/matrix_factorization_sgd.sv
`timescale 1ns / 1ps
`default_nettype none
// Matrix-factorization SGD engine. A load beat writes one factor element, if its
// feature index is in range. A predict beat does one table read and one
// multiply-accumulate per feature. A train beat with a positive rating walks
// the features a second time, reading both rows, forming both gradients in the
// cycle after the read and writing each updated element back the cycle after
// that.
// The finished result waits in an output register while the next beat is
// taken. The tables come up undefined and must be loaded before use.
module matrix_factorization_sgd import mfs_pkg::*; #(
    parameter int DOCS      = DEF_DOCS,
    parameter int TERMS     = DEF_TERMS,
    parameter int FEATURES  = DEF_FEATURES,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    mfs_in_if.sink    in_ch,
    mfs_out_if.source out_ch,
    mfs_cfg_if.sink   cfg_ch
);
    localparam int FAW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

    t_dp_cmd w_cmd;
    logic [$clog2(FEATURES+1)-1:0] w_feat;
    logic w_fd, w_pos, w_fok;

    assign cfg_ch.ready = 1'b1;

    mfs_ctrl #(.FEATURES(FEATURES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_command(in_ch.command), .o_in_ready(in_ch.ready),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid),
        .i_positive(w_pos), .i_feat_ok(w_fok),
        .o_cmd(w_cmd), .o_feat(w_feat), .o_feat_d(w_fd));

    mfs_datapath #(.DOCS(DOCS), .TERMS(TERMS), .FEATURES(FEATURES),
                   .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .i_feat(w_feat[FAW-1:0]), .i_feat_d(w_fd),
        .i_command(in_ch.command), .i_doc_sel(in_ch.doc_sel),
        .i_term_sel(in_ch.term_sel), .i_feature_index(in_ch.feature_index),
        .i_value(in_ch.value),
        .i_cfg_we(cfg_ch.valid), .i_cfg_index(cfg_ch.index), .i_cfg_data(cfg_ch.data),
        .o_positive(w_pos), .o_feat_ok(w_fok),
        .o_prediction(out_ch.prediction), .o_residual(out_ch.residual),
        .o_updated(out_ch.updated));
endmodule
`default_nettype wire
